// File: src/tppd_pkg.sv
// Shared types and constants of the tablet packet position decoder.
`default_nettype none

package tppd_pkg;

	// Field widths
	localparam int PAD_W   = 8;
	localparam int DATA_W  = 6;
	localparam int BTN_W   = 4;
	localparam int RAW_W   = 12;
	localparam int CAP_W   = 2 * RAW_W;
	localparam int PTS_W   = 13;
	localparam int X_W     = 13;
	localparam int Y_W     = 14;
	localparam int CNT_W   = 3;
	localparam int ADDR_W  = 3;
	localparam int APB_W   = 32;

	// Pad byte layout
	localparam int FLAG_BIT = 6;
	localparam int BTN_LSB  = 2;

	// Capture counter codes
	localparam logic [CNT_W-1:0] CAP_IDLE  = 3'd0;
	localparam logic [CNT_W-1:0] CAP_FIRST = 3'd1;
	localparam logic [CNT_W-1:0] CAP_LAST  = 3'd4;

	// Register map (index = byte address / 4)
	localparam logic [ADDR_W-3:0] REG_POINTS = 1'b0;

	// Points register
	localparam logic [PTS_W-1:0] POINTS_RESET = 13'd512;
	localparam logic [PTS_W-1:0] POINTS_MAX   = 13'd4096;

	// Pad full-scale span, default for the top level parameter
	localparam int PAD_SPAN_DEFAULT = 2200;

	// Output saturation limits
	localparam int X_MAX = 8191;
	localparam int Y_MAX = 8191;
	localparam int Y_MIN = -8192;

	// Snapshot of the chosen packet taken at batch end
	typedef struct packed {
		logic [CAP_W-1:0] raw;
		logic [BTN_W-1:0] buttons;
		logic             found;
	} snap_t;

endpackage

`default_nettype wire

// File: src/tppd_parser.sv
// Byte stream parser: packet capture, choice tracking and batch-end snapshot.
`default_nettype none

module tppd_parser (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [tppd_pkg::PAD_W-1:0] pad_byte,
	input  wire logic                      batch_end,
	output tppd_pkg::snap_t                snap_s1,
	output logic                           snap_valid_s1,
	input  wire logic                      snap_stall
);
	import tppd_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [BTN_W-1:0] btn_q, btn_n;
	logic [CAP_W-1:0] data_q, data_n;
	logic [BTN_W-1:0] ch_btn_q, ch_btn_n;
	logic [CAP_W-1:0] ch_raw_q, ch_raw_n;
	logic             ch_v_q, ch_v_n;
	logic             lock_q, lock_n;
	logic             accept;
	logic             s1_free;

	// A batch-end request needs the snapshot register free
	assign s1_free  = !snap_valid_s1 || !snap_stall;
	assign in_stall = batch_end && !s1_free;
	assign accept   = in_valid && !in_stall;

	// Next capture and choice state for the current byte
	always_comb begin
		cnt_n    = cnt_q;
		btn_n    = btn_q;
		data_n   = data_q;
		ch_btn_n = ch_btn_q;
		ch_raw_n = ch_raw_q;
		ch_v_n   = ch_v_q;
		lock_n   = lock_q;
		if (pad_byte[FLAG_BIT]) begin
			// flag byte (re)starts a packet
			btn_n  = pad_byte[BTN_LSB +: BTN_W];
			data_n = '0;
			cnt_n  = CAP_FIRST;
		end else if (cnt_q != CAP_IDLE) begin
			data_n[DATA_W * (int'(cnt_q) - 1) +: DATA_W] = pad_byte[DATA_W-1:0];
			if (cnt_q == CAP_LAST) begin
				// packet complete
				if (!lock_q) begin
					ch_btn_n = btn_q;
					ch_raw_n = data_n;
					ch_v_n   = 1'b1;
					if (btn_q != '0) begin
						lock_n = 1'b1;
					end
				end
				cnt_n = CAP_IDLE;
			end else begin
				cnt_n = cnt_q + CNT_W'(1);
			end
		end
	end

	// Parser state; cleared after every batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= CAP_IDLE;
			btn_q    <= '0;
			data_q   <= '0;
			ch_btn_q <= '0;
			ch_raw_q <= '0;
			ch_v_q   <= 1'b0;
			lock_q   <= 1'b0;
		end else if (accept) begin
			if (batch_end) begin
				cnt_q    <= CAP_IDLE;
				btn_q    <= '0;
				data_q   <= '0;
				ch_btn_q <= '0;
				ch_raw_q <= '0;
				ch_v_q   <= 1'b0;
				lock_q   <= 1'b0;
			end else begin
				cnt_q    <= cnt_n;
				btn_q    <= btn_n;
				data_q   <= data_n;
				ch_btn_q <= ch_btn_n;
				ch_raw_q <= ch_raw_n;
				ch_v_q   <= ch_v_n;
				lock_q   <= lock_n;
			end
		end
	end

	// Snapshot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (accept && batch_end) begin
			snap_valid_s1 <= 1'b1;
		end else if (!snap_stall) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	// Snapshot payload, includes the effect of the batch-end byte
	always_ff @(posedge clk) begin
		if (accept && batch_end) begin
			snap_s1.raw     <= ch_raw_n;
			snap_s1.buttons <= ch_btn_n;
			snap_s1.found   <= ch_v_n;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_LAST)
		else $error("capture counter out of range");

	a_batch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && batch_end |=> snap_valid_s1 && cnt_q == CAP_IDLE && !ch_v_q && !lock_q)
		else $error("batch end did not clear state or load snapshot");

endmodule

`default_nettype wire

// File: src/tppd_scaler.sv
// Scaling pipeline: raw times points, division by the pad span, output register.
`default_nettype none

module tppd_scaler #(
	parameter int PAD_SPAN = tppd_pkg::PAD_SPAN_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [tppd_pkg::PTS_W-1:0] points,
	input  wire tppd_pkg::snap_t            snap_s1,
	input  wire logic                       snap_valid_s1,
	output logic                            snap_stall,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [tppd_pkg::X_W-1:0]        x_position,
	output logic signed [tppd_pkg::Y_W-1:0] y_position,
	output logic [tppd_pkg::BTN_W-1:0]      button_bits,
	output logic                            found
);
	import tppd_pkg::*;

	// Exact reciprocal of PAD_SPAN for NUM_W-bit products
	localparam int NUM_W   = RAW_W + PTS_W;
	localparam int SHIFT   = NUM_W + $clog2(PAD_SPAN);
	localparam int RECIP_W = NUM_W + 2;
	localparam int PROD_W  = SHIFT + NUM_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(PAD_SPAN) - 64'd1) / 64'(PAD_SPAN));
	localparam logic [NUM_W-1:0]        X_HI = NUM_W'(X_MAX);
	localparam logic signed [NUM_W:0]   Y_HI = (NUM_W + 1)'(Y_MAX);
	localparam logic signed [NUM_W:0]   Y_LO = (NUM_W + 1)'(Y_MIN);

	logic             s2_v, s3_v;
	logic             s2_free, s3_free, out_free;
	logic [PTS_W-1:0] span;
	logic [NUM_W-1:0] px_s2, py_s2;
	logic [PTS_W-1:0] span_s2, span_s3;
	logic [BTN_W-1:0] btn_s2, btn_s3;
	logic             fnd_s2, fnd_s3;
	logic [NUM_W-1:0] qx_s3, qy_s3;
	logic [PROD_W-1:0] qx_full, qy_full;
	logic signed [NUM_W:0] y_diff;

	// Stage flow control: a stage loads when empty or when it moves on
	assign out_free   = !out_valid || !out_stall;
	assign s3_free    = !s3_v || out_free;
	assign s2_free    = !s2_v || s3_free;
	assign snap_stall = !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v      <= 1'b0;
			s3_v      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s2_free) begin
				s2_v <= snap_valid_s1;
			end
			if (s3_free) begin
				s3_v <= s2_v;
			end
			if (out_free) begin
				out_valid <= s3_v;
			end
		end
	end

	// Points clamped to the pad's resolution
	assign span = (points > POINTS_MAX) ? POINTS_MAX : points;

	// Stage 2: raw coordinate times span
	always_ff @(posedge clk) begin
		if (s2_free) begin
			px_s2   <= NUM_W'(snap_s1.raw[RAW_W-1:0]) * NUM_W'(span);
			py_s2   <= NUM_W'(snap_s1.raw[CAP_W-1:RAW_W]) * NUM_W'(span);
			span_s2 <= span;
			btn_s2  <= snap_s1.buttons;
			fnd_s2  <= snap_s1.found;
		end
	end

	// Stage 3: divide by the pad span through the reciprocal
	assign qx_full = PROD_W'(px_s2) * PROD_W'(RECIP);
	assign qy_full = PROD_W'(py_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (s3_free) begin
			qx_s3   <= qx_full[SHIFT +: NUM_W];
			qy_s3   <= qy_full[SHIFT +: NUM_W];
			span_s3 <= span_s2;
			btn_s3  <= btn_s2;
			fnd_s3  <= fnd_s2;
		end
	end

	// Output stage: y from the span, saturation, empty batch gives zeros
	assign y_diff = $signed({{(NUM_W + 1 - PTS_W){1'b0}}, span_s3})
		- $signed({1'b0, qy_s3});

	always_ff @(posedge clk) begin
		if (out_free) begin
			found       <= fnd_s3;
			button_bits <= btn_s3;
			if (!fnd_s3) begin
				x_position <= '0;
				y_position <= '0;
			end else begin
				x_position <= (qx_s3 > X_HI) ? X_HI[X_W-1:0] : qx_s3[X_W-1:0];
				if (y_diff > Y_HI) begin
					y_position <= Y_HI[Y_W-1:0];
				end else if (y_diff < Y_LO) begin
					y_position <= Y_LO[Y_W-1:0];
				end else begin
					y_position <= y_diff[Y_W-1:0];
				end
			end
		end
	end

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> x_position == '0 && y_position == '0 && button_bits == '0)
		else $error("empty batch result carries nonzero fields");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s3_v && out_valid && out_stall |=> s3_v && $stable(qx_s3) && $stable(qy_s3))
		else $error("stage 3 lost data under stall");

endmodule

`default_nettype wire

// File: src/tablet_packet_position_decoder.sv
// Top level of the tablet packet position decoder with its points register.
//
// Takes one pad byte per clock cycle. Bytes are always accepted except a byte
// that ends a batch while the snapshot register is still full behind a stalled
// result. A batch-end request yields one result, which passes in turn through
// the snapshot, multiply, reciprocal-divide and output registers; batches can
// follow each other byte by byte. The points register lies at byte address 0
// and should be written only while no result is pending; values above 4096
// act as 4096.
`default_nettype none

module tablet_packet_position_decoder #(
	parameter int PAD_SPAN = tppd_pkg::PAD_SPAN_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// pad byte channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [tppd_pkg::PAD_W-1:0]  pad_byte,
	input  wire logic                        batch_end,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [tppd_pkg::X_W-1:0]         x_position,
	output logic signed [tppd_pkg::Y_W-1:0]  y_position,
	output logic [tppd_pkg::BTN_W-1:0]       button_bits,
	output logic                             found,
	// configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tppd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [tppd_pkg::APB_W-1:0]  pwdata,
	output logic [tppd_pkg::APB_W-1:0]       prdata,
	output logic                             pready
);
	import tppd_pkg::*;

	logic [PTS_W-1:0] points_q;
	snap_t            snap_s1;
	logic             snap_valid_s1;
	logic             snap_stall;
	logic             reg_hit;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_POINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= POINTS_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			points_q <= pwdata[PTS_W-1:0];
		end
	end

	assign prdata = reg_hit ? {{(APB_W - PTS_W){1'b0}}, points_q} : '0;

	tppd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pad_byte      (pad_byte),
		.batch_end     (batch_end),
		.snap_s1       (snap_s1),
		.snap_valid_s1 (snap_valid_s1),
		.snap_stall    (snap_stall)
	);

	tppd_scaler #(
		.PAD_SPAN (PAD_SPAN)
	) u_scaler (
		.clk           (clk),
		.arst_n        (arst_n),
		.points        (points_q),
		.snap_s1       (snap_s1),
		.snap_valid_s1 (snap_valid_s1),
		.snap_stall    (snap_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.x_position    (x_position),
		.y_position    (y_position),
		.button_bits   (button_bits),
		.found         (found)
	);

endmodule

`default_nettype wire
